### rtl/snea_pkg.sv
// ----------------------------------------------------------------------------
// snea_pkg
// shared types and codes of the sparse normal-equation accumulator
// ----------------------------------------------------------------------------
package snea_pkg;

  localparam int unsigned CellW  = 12;
  localparam int unsigned WeightW = 16;
  localparam int unsigned ValW   = 48;
  localparam int unsigned CountW = 17;
  localparam int unsigned InitDiag = 268;

  typedef enum logic [1:0] {
    OP_ELEM    = 2'd0,
    OP_RD_GRAD = 2'd1,
    OP_RD_MAT  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_LONG   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_TAKE,
    CMD_DECODE,
    CMD_GR_RD,
    CMD_GR_RES,
    CMD_M_CS0,
    CMD_CS_LO,
    CMD_CS_HI,
    CMD_SRCH,
    CMD_CMP_ACC,
    CMD_CMP_RD,
    CMD_ABSENT,
    CMD_G_CHK,
    CMD_BUF_RD_I,
    CMD_G_MUL,
    CMD_G_WR,
    CMD_P_RDJ,
    CMD_P_CS0,
    CMD_INS_START,
    CMD_SH_RD,
    CMD_SH_WR,
    CMD_INS_WR,
    CMD_C_RD,
    CMD_C_WR,
    CMD_P_NEXT,
    CMD_FINISH,
    CMD_RESP
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    op_e  op;
    logic in_range;
    logic room;
    logic last;
    logic i_eq_len;
    logic k_lt_hi;
    logic er_lt;
    logic er_eq;
    logic store_full;
    logic p_gt_k;
    logic c_done;
    logic clr_done;
    logic out_free;
  } status_t;

endpackage

### rtl/snea_ctrl.sv
// ----------------------------------------------------------------------------
// snea_ctrl
// sequencer for requests, row updates, sorted insertion and matrix reads
// ----------------------------------------------------------------------------
module snea_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  snea_pkg::status_t sts_i,
  output snea_pkg::ctrl_t   ctrl_o
);

  typedef enum logic [33:0] {
    S_CLEAR   = 34'h000000001,
    S_IDLE    = 34'h000000002,
    S_DECODE  = 34'h000000004,
    S_GR_RD   = 34'h000000008,
    S_GR_RES  = 34'h000000010,
    S_M_CS0   = 34'h000000020,
    S_M_LO    = 34'h000000040,
    S_M_HI    = 34'h000000080,
    S_M_SRCH  = 34'h000000100,
    S_M_CMP   = 34'h000000200,
    S_M_FAIL  = 34'h000000400,
    S_G_CHK   = 34'h000000800,
    S_G_RD    = 34'h000001000,
    S_G_MUL   = 34'h000002000,
    S_G_WR    = 34'h000004000,
    S_P_CHK   = 34'h000008000,
    S_P_RDI   = 34'h000010000,
    S_P_RDJ   = 34'h000020000,
    S_P_CS0   = 34'h000040000,
    S_P_LO    = 34'h000080000,
    S_P_HI    = 34'h000100000,
    S_P_SRCH  = 34'h000200000,
    S_P_CMP   = 34'h000400000,
    S_P_INS   = 34'h000800000,
    S_SH_CHK  = 34'h001000000,
    S_SH_RD   = 34'h002000000,
    S_SH_WR   = 34'h004000000,
    S_INS_WR  = 34'h008000000,
    S_C_CHK   = 34'h010000000,
    S_C_RD    = 34'h020000000,
    S_C_WR    = 34'h040000000,
    S_P_NEXT  = 34'h080000000,
    S_FINISH  = 34'h100000000,
    S_RESP    = 34'h200000000
  } state_e;

  state_e state_q, state_d;
  snea_pkg::cmd_e cmd;

  assign s_tready_o = (state_q == S_IDLE);
  assign ctrl_o.cmd = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = snea_pkg::CMD_NONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd = snea_pkg::CMD_CLEAR;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd     = snea_pkg::CMD_TAKE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd = snea_pkg::CMD_DECODE;
        unique case (sts_i.op)
          snea_pkg::OP_ELEM: begin
            if (sts_i.last) state_d = S_G_CHK;
            else if (sts_i.in_range && !sts_i.room) state_d = S_RESP;
            else state_d = S_IDLE;
          end
          snea_pkg::OP_RD_GRAD: state_d = sts_i.in_range ? S_GR_RD : S_M_FAIL;
          snea_pkg::OP_RD_MAT:  state_d = sts_i.in_range ? S_M_CS0 : S_M_FAIL;
          default:              state_d = S_IDLE;
        endcase
      end
      S_GR_RD: begin
        cmd     = snea_pkg::CMD_GR_RD;
        state_d = S_GR_RES;
      end
      S_GR_RES: begin
        cmd     = snea_pkg::CMD_GR_RES;
        state_d = S_RESP;
      end
      S_M_CS0: begin
        cmd     = snea_pkg::CMD_M_CS0;
        state_d = S_M_LO;
      end
      S_M_LO: begin
        cmd     = snea_pkg::CMD_CS_LO;
        state_d = S_M_HI;
      end
      S_M_HI: begin
        cmd     = snea_pkg::CMD_CS_HI;
        state_d = S_M_SRCH;
      end
      S_M_SRCH: begin
        cmd     = snea_pkg::CMD_SRCH;
        state_d = sts_i.k_lt_hi ? S_M_CMP : S_M_FAIL;
      end
      S_M_CMP: begin
        cmd     = snea_pkg::CMD_CMP_RD;
        state_d = sts_i.er_eq ? S_RESP : S_M_SRCH;
      end
      S_M_FAIL: begin
        cmd     = snea_pkg::CMD_ABSENT;
        state_d = S_RESP;
      end
      S_G_CHK: begin
        cmd     = snea_pkg::CMD_G_CHK;
        state_d = sts_i.i_eq_len ? S_P_CHK : S_G_RD;
      end
      S_G_RD: begin
        cmd     = snea_pkg::CMD_BUF_RD_I;
        state_d = S_G_MUL;
      end
      S_G_MUL: begin
        cmd     = snea_pkg::CMD_G_MUL;
        state_d = S_G_WR;
      end
      S_G_WR: begin
        cmd     = snea_pkg::CMD_G_WR;
        state_d = S_G_CHK;
      end
      S_P_CHK: begin
        state_d = sts_i.i_eq_len ? S_FINISH : S_P_RDI;
      end
      S_P_RDI: begin
        cmd     = snea_pkg::CMD_BUF_RD_I;
        state_d = S_P_RDJ;
      end
      S_P_RDJ: begin
        cmd     = snea_pkg::CMD_P_RDJ;
        state_d = S_P_CS0;
      end
      S_P_CS0: begin
        cmd     = snea_pkg::CMD_P_CS0;
        state_d = S_P_LO;
      end
      S_P_LO: begin
        cmd     = snea_pkg::CMD_CS_LO;
        state_d = S_P_HI;
      end
      S_P_HI: begin
        cmd     = snea_pkg::CMD_CS_HI;
        state_d = S_P_SRCH;
      end
      S_P_SRCH: begin
        cmd     = snea_pkg::CMD_SRCH;
        state_d = sts_i.k_lt_hi ? S_P_CMP : S_P_INS;
      end
      S_P_CMP: begin
        cmd = snea_pkg::CMD_CMP_ACC;
        if (sts_i.er_eq) state_d = S_P_NEXT;
        else if (sts_i.er_lt) state_d = S_P_SRCH;
        else state_d = S_P_INS;
      end
      S_P_INS: begin
        cmd     = snea_pkg::CMD_INS_START;
        state_d = sts_i.store_full ? S_P_NEXT : S_SH_CHK;
      end
      S_SH_CHK: begin
        state_d = sts_i.p_gt_k ? S_SH_RD : S_INS_WR;
      end
      S_SH_RD: begin
        cmd     = snea_pkg::CMD_SH_RD;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        cmd     = snea_pkg::CMD_SH_WR;
        state_d = S_SH_CHK;
      end
      S_INS_WR: begin
        cmd     = snea_pkg::CMD_INS_WR;
        state_d = S_C_CHK;
      end
      S_C_CHK: begin
        state_d = sts_i.c_done ? S_P_NEXT : S_C_RD;
      end
      S_C_RD: begin
        cmd     = snea_pkg::CMD_C_RD;
        state_d = S_C_WR;
      end
      S_C_WR: begin
        cmd     = snea_pkg::CMD_C_WR;
        state_d = S_C_CHK;
      end
      S_P_NEXT: begin
        cmd     = snea_pkg::CMD_P_NEXT;
        state_d = S_P_CHK;
      end
      S_FINISH: begin
        cmd     = snea_pkg::CMD_FINISH;
        state_d = S_RESP;
      end
      S_RESP: begin
        cmd = snea_pkg::CMD_RESP;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/snea_dp.sv
// ----------------------------------------------------------------------------
// snea_dp
// row buffer, gradient and sparse matrix stores, pointers and output register
// ----------------------------------------------------------------------------
module snea_dp #(
  parameter int unsigned NUM_CELLS   = 4096,
  parameter int unsigned MAX_ENTRIES = 65536,
  parameter int unsigned MAX_ROW     = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  snea_pkg::ctrl_t   ctrl_i,
  output snea_pkg::status_t sts_o,
  input  logic [1:0]        op_i,
  input  logic [11:0]       cell_i,
  input  logic [11:0]       row_cell_i,
  input  logic [15:0]       weight_i,
  input  logic [15:0]       conc_i,
  input  logic              last_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [47:0]       value_o,
  output logic [16:0]       count_o,
  output logic [1:0]        status_o
);

  localparam int unsigned Diag = (NUM_CELLS < MAX_ENTRIES) ? NUM_CELLS : MAX_ENTRIES;
  localparam int unsigned CAW  = $clog2(NUM_CELLS);
  localparam int unsigned CXW  = (CAW > 12) ? CAW : 12;
  localparam int unsigned CSW  = $clog2(NUM_CELLS + 1);
  localparam int unsigned CCW  = $clog2(NUM_CELLS + 2);
  localparam int unsigned EAW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW   = $clog2(MAX_ROW + 1);
  localparam int unsigned BAW  = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  logic [11:0] bc_mem [MAX_ROW];
  logic [15:0] bw_mem [MAX_ROW];
  logic [47:0] gr_mem [NUM_CELLS];
  logic [CW-1:0] cs_mem [NUM_CELLS + 1];
  logic [11:0] er_mem [MAX_ENTRIES];
  logic [47:0] ev_mem [MAX_ENTRIES];

  logic [11:0] bc_rd_q;
  logic [15:0] bw_rd_q;
  logic [47:0] gr_rd_q;
  logic [CW-1:0] cs_rd_q;
  logic [11:0] er_rd_q;
  logic [47:0] ev_rd_q;

  logic           b_we, b_re;
  logic [BAW-1:0] b_wa, b_ra;
  logic           g_we, g_re;
  logic [CAW-1:0] g_wa, g_ra;
  logic [47:0]    g_wd;
  logic           c_we, c_re;
  logic [CSW-1:0] c_wa, c_ra;
  logic [CW-1:0]  c_wd;
  logic           er_we, ev_we, e_re;
  logic [EAW-1:0] e_wa, e_ra;
  logic [11:0]    er_wd;
  logic [47:0]    ev_wd;

  snea_pkg::op_e op_q, op_d;
  logic [11:0] cell_q, cell_d, rowc_q, rowc_d;
  logic [15:0] w_q, w_d, conc_q, conc_d;
  logic        last_q, last_d;
  logic [LW-1:0] len_q, len_d, i_q, i_d, j_q, j_d;
  logic        dropped_q, dropped_d, full_q, full_d;
  logic [CAW-1:0] ci_q, ci_d;
  logic [15:0] wi_q, wi_d;
  logic [11:0] r_q, r_d;
  logic [31:0] prod_q, prod_d;
  logic [CW-1:0] k_q, k_d, hi_q, hi_d, p_q, p_d, count_q, count_d;
  logic [CCW-1:0] c_q, c_d;
  logic [CSW-1:0] ptr_q, ptr_d;
  logic [47:0] res_value_q, res_value_d;
  snea_pkg::status_e res_status_q, res_status_d;
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_value_q, out_value_d;
  logic [16:0] out_count_q, out_count_d;
  logic [1:0]  out_status_q, out_status_d;

  logic [CXW-1:0] cell_x, bc_x;
  logic [CAW-1:0] cell_a, bc_a;
  logic [48:0] g_diff, e_sum;
  logic [EAW-1:0] k_a, p_a;
  logic [CW-1:0] p_m1;
  logic [CSW-1:0] ci_p1;

  function automatic logic [47:0] sat48(input logic [48:0] v);
    logic [47:0] r;
    if (v[48] != v[47]) r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else r = v[47:0];
    return r;
  endfunction

  assign cell_x = CXW'(cell_q);
  assign cell_a = cell_x[CAW-1:0];
  assign bc_x   = CXW'(bc_rd_q);
  assign bc_a   = bc_x[CAW-1:0];
  assign g_diff = {gr_rd_q[47], gr_rd_q} - (49'(prod_q) << 15);
  assign e_sum  = {ev_rd_q[47], ev_rd_q} + 49'(prod_q);
  assign k_a    = k_q[EAW-1:0];
  assign p_a    = p_q[EAW-1:0];
  assign p_m1   = p_q - CW'(1);
  assign ci_p1  = CSW'(ci_q) + CSW'(1);

  assign sts_o.op         = op_q;
  assign sts_o.in_range   = (32'(cell_q) < NUM_CELLS);
  assign sts_o.room       = (32'(len_q) < MAX_ROW);
  assign sts_o.last       = last_q;
  assign sts_o.i_eq_len   = (i_q == len_q);
  assign sts_o.k_lt_hi    = (k_q < hi_q);
  assign sts_o.er_lt      = (er_rd_q < r_q);
  assign sts_o.er_eq      = (er_rd_q == r_q);
  assign sts_o.store_full = (32'(count_q) >= MAX_ENTRIES);
  assign sts_o.p_gt_k     = (p_q > k_q);
  assign sts_o.c_done     = (32'(c_q) > NUM_CELLS);
  assign sts_o.clr_done   = (32'(ptr_q) == NUM_CELLS);
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign value_o    = out_value_q;
  assign count_o    = out_count_q;
  assign status_o   = out_status_q;

  always_comb begin
    op_d = op_q; cell_d = cell_q; rowc_d = rowc_q; w_d = w_q; conc_d = conc_q;
    last_d = last_q; len_d = len_q; i_d = i_q; j_d = j_q; dropped_d = dropped_q;
    full_d = full_q; ci_d = ci_q; wi_d = wi_q; r_d = r_q; prod_d = prod_q;
    k_d = k_q; hi_d = hi_q; p_d = p_q; count_d = count_q; c_d = c_q; ptr_d = ptr_q;
    res_value_d = res_value_q; res_status_d = res_status_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_value_d = out_value_q; out_count_d = out_count_q; out_status_d = out_status_q;
    b_we = 1'b0; b_re = 1'b0; b_wa = len_q[BAW-1:0]; b_ra = i_q[BAW-1:0];
    g_we = 1'b0; g_re = 1'b0; g_wa = ci_q; g_ra = cell_a; g_wd = sat48(g_diff);
    c_we = 1'b0; c_re = 1'b0; c_wa = CSW'(c_q); c_ra = CSW'(ci_q); c_wd = cs_rd_q + CW'(1);
    er_we = 1'b0; ev_we = 1'b0; e_re = 1'b0; e_wa = k_a; e_ra = k_a;
    er_wd = r_q; ev_wd = 48'(prod_q);
    case (ctrl_i.cmd)
      snea_pkg::CMD_CLEAR: begin
        g_we  = (32'(ptr_q) < NUM_CELLS);
        g_wa  = CAW'(ptr_q);
        g_wd  = '0;
        c_we  = 1'b1;
        c_wa  = ptr_q;
        c_wd  = (32'(ptr_q) < Diag) ? CW'(ptr_q) : CW'(Diag);
        er_we = (32'(ptr_q) < Diag);
        ev_we = (32'(ptr_q) < Diag);
        e_wa  = EAW'(ptr_q);
        er_wd = 12'(ptr_q);
        ev_wd = 48'(snea_pkg::InitDiag);
        ptr_d = ptr_q + CSW'(1);
      end
      snea_pkg::CMD_TAKE: begin
        op_d   = snea_pkg::op_e'(op_i);
        cell_d = cell_i;
        rowc_d = row_cell_i;
        w_d    = weight_i;
        conc_d = conc_i;
        last_d = last_i;
      end
      snea_pkg::CMD_DECODE: begin
        res_value_d  = '0;
        res_status_d = snea_pkg::ST_LONG;
        i_d = '0;
        j_d = '0;
        full_d = 1'b0;
        if (op_q == snea_pkg::OP_ELEM && sts_o.in_range) begin
          if (sts_o.room) begin
            b_we  = 1'b1;
            len_d = len_q + LW'(1);
          end else begin
            dropped_d = 1'b1;
          end
        end
      end
      snea_pkg::CMD_GR_RD: begin
        g_re = 1'b1;
        g_ra = cell_a;
      end
      snea_pkg::CMD_GR_RES: begin
        res_value_d  = gr_rd_q;
        res_status_d = snea_pkg::ST_OK;
      end
      snea_pkg::CMD_M_CS0: begin
        ci_d = cell_a;
        r_d  = rowc_q;
        c_re = 1'b1;
        c_ra = CSW'(cell_a);
      end
      snea_pkg::CMD_CS_LO: begin
        k_d  = cs_rd_q;
        c_re = 1'b1;
        c_ra = ci_p1;
      end
      snea_pkg::CMD_CS_HI: begin
        hi_d = cs_rd_q;
      end
      snea_pkg::CMD_SRCH: begin
        e_re = sts_o.k_lt_hi;
        e_ra = k_a;
      end
      snea_pkg::CMD_CMP_ACC: begin
        if (sts_o.er_eq) begin
          ev_we = 1'b1;
          ev_wd = sat48(e_sum);
        end else if (sts_o.er_lt) begin
          k_d = k_q + CW'(1);
        end
      end
      snea_pkg::CMD_CMP_RD: begin
        if (sts_o.er_eq) begin
          res_value_d  = ev_rd_q;
          res_status_d = snea_pkg::ST_OK;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      snea_pkg::CMD_ABSENT: begin
        res_value_d  = '0;
        res_status_d = snea_pkg::ST_ABSENT;
      end
      snea_pkg::CMD_G_CHK: begin
        if (sts_o.i_eq_len) i_d = '0;
      end
      snea_pkg::CMD_BUF_RD_I: begin
        b_re = 1'b1;
        b_ra = i_q[BAW-1:0];
      end
      snea_pkg::CMD_G_MUL: begin
        ci_d   = bc_a;
        prod_d = 32'(conc_q) * 32'(bw_rd_q);
        g_re   = 1'b1;
        g_ra   = bc_a;
      end
      snea_pkg::CMD_G_WR: begin
        g_we = 1'b1;
        g_wa = ci_q;
        i_d  = i_q + LW'(1);
      end
      snea_pkg::CMD_P_RDJ: begin
        ci_d = bc_a;
        wi_d = bw_rd_q;
        b_re = 1'b1;
        b_ra = j_q[BAW-1:0];
      end
      snea_pkg::CMD_P_CS0: begin
        r_d    = bc_rd_q;
        prod_d = 32'(wi_q) * 32'(bw_rd_q);
        c_re   = 1'b1;
        c_ra   = CSW'(ci_q);
      end
      snea_pkg::CMD_INS_START: begin
        p_d = count_q;
        if (sts_o.store_full) full_d = 1'b1;
      end
      snea_pkg::CMD_SH_RD: begin
        e_re = 1'b1;
        e_ra = p_m1[EAW-1:0];
      end
      snea_pkg::CMD_SH_WR: begin
        er_we = 1'b1;
        ev_we = 1'b1;
        e_wa  = p_a;
        er_wd = er_rd_q;
        ev_wd = ev_rd_q;
        p_d   = p_m1;
      end
      snea_pkg::CMD_INS_WR: begin
        er_we   = 1'b1;
        ev_we   = 1'b1;
        e_wa    = k_a;
        count_d = count_q + CW'(1);
        c_d     = CCW'(ci_p1);
      end
      snea_pkg::CMD_C_RD: begin
        c_re = 1'b1;
        c_ra = CSW'(c_q);
      end
      snea_pkg::CMD_C_WR: begin
        c_we = 1'b1;
        c_wa = CSW'(c_q);
        c_d  = c_q + CCW'(1);
      end
      snea_pkg::CMD_P_NEXT: begin
        if ((j_q + LW'(1)) == len_q) begin
          j_d = '0;
          i_d = i_q + LW'(1);
        end else begin
          j_d = j_q + LW'(1);
        end
      end
      snea_pkg::CMD_FINISH: begin
        res_value_d = '0;
        if (full_q) res_status_d = snea_pkg::ST_FULL;
        else if (dropped_q) res_status_d = snea_pkg::ST_LONG;
        else res_status_d = snea_pkg::ST_OK;
        len_d     = '0;
        dropped_d = 1'b0;
      end
      snea_pkg::CMD_RESP: begin
        if (sts_o.out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_count_d  = 17'(count_q);
          out_status_d = res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bc_mem[b_wa] <= cell_q;
      bw_mem[b_wa] <= w_q;
    end
    if (b_re) begin
      bc_rd_q <= bc_mem[b_ra];
      bw_rd_q <= bw_mem[b_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) gr_mem[g_wa] <= g_wd;
    if (g_re) gr_rd_q <= gr_mem[g_ra];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cs_mem[c_wa] <= c_wd;
    if (c_re) cs_rd_q <= cs_mem[c_ra];
  end

  always_ff @(posedge clk_i) begin
    if (er_we) er_mem[e_wa] <= er_wd;
    if (ev_we) ev_mem[e_wa] <= ev_wd;
    if (e_re) begin
      er_rd_q <= er_mem[e_ra];
      ev_rd_q <= ev_mem[e_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      dropped_q   <= 1'b0;
      ptr_q       <= '0;
      count_q     <= CW'(Diag);
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      dropped_q   <= dropped_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; cell_q <= cell_d; rowc_q <= rowc_d; w_q <= w_d; conc_q <= conc_d;
    last_q <= last_d; i_q <= i_d; j_q <= j_d; full_q <= full_d; ci_q <= ci_d;
    wi_q <= wi_d; r_q <= r_d; prod_q <= prod_d; k_q <= k_d; hi_q <= hi_d;
    p_q <= p_d; c_q <= c_d; res_value_q <= res_value_d; res_status_q <= res_status_d;
    out_value_q <= out_value_d; out_count_q <= out_count_d; out_status_q <= out_status_d;
  end

endmodule

### rtl/sparse_normal_equation_accumulator.sv
// ----------------------------------------------------------------------------
// sparse_normal_equation_accumulator
// gathers measurement rows into a gradient and a column-compressed matrix
// ----------------------------------------------------------------------------
// row elements are buffered; a matrix read compares the column's entries in turn until the row is found
//   (or until the column end is reached, when the entry is absent)
// last element: each buffered element updates the gradient, then each pair searches its column,
//   and an insertion moves the entries after it and bumps each column start after the column
// one request at a time; the next is taken once the result, if any, is in the output register
// after reset a clearing pass over the gradient, column starts and diagonal entries runs before any request is taken
module sparse_normal_equation_accumulator #(
  parameter int unsigned NUM_CELLS   = 4096,
  parameter int unsigned MAX_ENTRIES = 65536,
  parameter int unsigned MAX_ROW     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [55:0] s_tdata_i,  // cell_index, row_cell, weight, concentration
  input  logic [1:0]  s_tuser_i,  // operation
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [71:0] m_tdata_o   // read_value, stored_entries, status, zero pad
);

  snea_pkg::ctrl_t   ctrl;
  snea_pkg::status_t sts;
  logic [47:0] value;
  logic [16:0] count;
  logic [1:0]  status;

  assign m_tdata_o = {5'd0, status, count, value};

  snea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  snea_dp #(
    .NUM_CELLS   (NUM_CELLS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_ROW     (MAX_ROW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sts_o      (sts),
    .op_i       (s_tuser_i),
    .cell_i     (s_tdata_i[11:0]),
    .row_cell_i (s_tdata_i[23:12]),
    .weight_i   (s_tdata_i[39:24]),
    .conc_i     (s_tdata_i[55:40]),
    .last_i     (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .value_o    (value),
    .count_o    (count),
    .status_o   (status)
  );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// stream testbench of the sparse normal-equation accumulator: rows and reads
// go in with random gaps, a scoreboard predicts every response and compares
// it field by field
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCells = 4096;
  localparam int unsigned MaxEnt = 65536;
  localparam int unsigned MaxRow = 64;
  localparam longint ValMax = 64'sd140737488355327;
  localparam longint ValMin = -ValMax - 1;
  localparam int unsigned CycleLimit = 4000000;

  typedef struct {
    longint            value;
    int                count;
    snea_pkg::status_e st;
  } response_t;

  class accum_scoreboard;
    logic [11:0] buf_cell[MaxRow];
    logic [15:0] buf_wt[MaxRow];
    int          buf_len;
    bit          buf_dropped;
    longint      grad[NCells];
    int          col_start[NCells+1];
    logic [11:0] ent_row[MaxEnt];
    longint      ent_val[MaxEnt];
    int          ent_count;
    response_t   pending[$];
    int          errors;

    function new();
      for (int k = 0; k <= NCells; k++) col_start[k] = k;
      for (int k = 0; k < NCells; k++) begin
        ent_row[k] = k[11:0];
        ent_val[k] = snea_pkg::InitDiag;
        grad[k] = 0;
      end
      ent_count = NCells;
      buf_len = 0;
      buf_dropped = 0;
      errors = 0;
    endfunction

    function longint clamp(longint v);
      if (v > ValMax) return ValMax;
      if (v < ValMin) return ValMin;
      return v;
    endfunction

    function bit accumulate(int col, logic [11:0] r, longint amount);
      int lo;
      int hi;
      int k;
      lo = col_start[col];
      hi = col_start[col+1];
      k = lo;
      while (k < hi && ent_row[k] < r) k++;
      if (k < hi && ent_row[k] == r) begin
        ent_val[k] = clamp(ent_val[k] + amount);
        return 1;
      end
      if (ent_count >= MaxEnt) return 0;
      for (int m = ent_count; m > k; m--) begin
        ent_row[m] = ent_row[m-1];
        ent_val[m] = ent_val[m-1];
      end
      ent_row[k] = r;
      ent_val[k] = clamp(amount);
      ent_count++;
      for (int c = col + 1; c <= NCells; c++) col_start[c]++;
      return 1;
    endfunction

    function void note_request(snea_pkg::op_e op, logic [11:0] cell_idx, logic [11:0] rowc,
                               logic [15:0] w, logic [15:0] conc, logic last);
      response_t rsp;
      bit full;
      longint d;
      rsp.value = 0;
      rsp.st = snea_pkg::ST_OK;
      case (op)
        snea_pkg::OP_ELEM: begin
          if (buf_len < MaxRow) begin
            buf_cell[buf_len] = cell_idx;
            buf_wt[buf_len] = w;
            buf_len++;
          end else begin
            buf_dropped = 1;
            if (!last) rsp.st = snea_pkg::ST_LONG;
          end
          if (!last && rsp.st == snea_pkg::ST_OK) return;
          if (last) begin
            full = 0;
            for (int i = 0; i < buf_len; i++) begin
              d = 2 * longint'(conc) * longint'(buf_wt[i]) * 16384;
              grad[buf_cell[i]] = clamp(grad[buf_cell[i]] - d);
            end
            for (int i = 0; i < buf_len; i++)
              for (int j = 0; j < buf_len; j++)
                if (!accumulate(buf_cell[i], buf_cell[j],
                                longint'(buf_wt[i]) * longint'(buf_wt[j])))
                  full = 1;
            rsp.st = full ? snea_pkg::ST_FULL :
                     (buf_dropped ? snea_pkg::ST_LONG : snea_pkg::ST_OK);
            buf_len = 0;
            buf_dropped = 0;
          end
        end
        snea_pkg::OP_RD_GRAD: rsp.value = grad[cell_idx];
        snea_pkg::OP_RD_MAT: begin
          rsp.st = snea_pkg::ST_ABSENT;
          for (int k = col_start[cell_idx]; k < col_start[cell_idx+1]; k++)
            if (ent_row[k] == rowc) begin
              rsp.value = ent_val[k];
              rsp.st = snea_pkg::ST_OK;
              break;
            end
        end
        default: return;
      endcase
      rsp.count = ent_count;
      pending.push_back(rsp);
    endfunction

    function void check_result(logic [71:0] data);
      response_t rsp;
      longint got;
      if (pending.size() == 0) begin
        $error("unexpected response %h", data);
        errors++;
        return;
      end
      rsp = pending.pop_front();
      got = longint'($signed(data[47:0]));
      if (got !== rsp.value) begin
        $error("read_value expected %0d actual %0d", rsp.value, got);
        errors++;
      end
      if (int'(data[64:48]) !== (rsp.count & 32'h1ffff)) begin
        $error("stored_entries expected %0d actual %0d", rsp.count, data[64:48]);
        errors++;
      end
      if (data[66:65] !== rsp.st) begin
        $error("status expected %0d actual %0d", rsp.st, data[66:65]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid_i = 0;
  logic        s_tready_o;
  logic [55:0] s_tdata_i = '0;
  logic [1:0]  s_tuser_i = '0;
  logic        s_tlast_i = 0;
  logic        m_tvalid_o;
  logic        m_tready_i = 0;
  logic [71:0] m_tdata_o;

  accum_scoreboard sb;
  int  n_items;
  int  n_results;
  bit  calm_in;
  logic [11:0] recent[8];

  sparse_normal_equation_accumulator u_top (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("sparse_normal_equation_accumulator verification failed");
        $finish;
      end
    end
  end

  // response side: random stall, one long hold-off to back up the input
  initial begin
    int hold;
    bit held_once;
    hold = 0;
    held_once = 0;
    n_results = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_tready_i = 0;
      end else if (!held_once && n_results == 30 && m_tvalid_o) begin
        hold = 400;
        held_once = 1;
        m_tready_i = 0;
      end else if (n_results >= 100 && n_results < 160) begin
        m_tready_i = 1;
      end else begin
        m_tready_i = ($urandom_range(0, 99) >= 21);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      sb.check_result(m_tdata_o);
      n_results++;
    end
  end

  task automatic send(snea_pkg::op_e op, logic [11:0] cell_idx, logic [11:0] rowc,
                      logic [15:0] w, logic [15:0] conc, logic last);
    if (!calm_in && $urandom_range(0, 99) < 21) begin
      s_tvalid_i = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_tdata_i = {conc, w, rowc, cell_idx};
    s_tuser_i = op;
    s_tlast_i = last;
    s_tvalid_i = 1;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_request(op, cell_idx, rowc, w, conc, last);
    n_items++;
    recent[$urandom_range(0, 7)] = cell_idx;
    @(negedge clk_i);
  endtask

  task automatic send_row(int len, bit high_cells);
    logic [11:0] c;
    for (int i = 0; i < len; i++) begin
      c = high_cells ? 12'($urandom_range(4064, 4095)) : 12'($urandom);
      send(snea_pkg::OP_ELEM, c, 12'($urandom), 16'($urandom), 16'($urandom),
           i == len - 1);
    end
  endtask

  initial begin
    int r;
    int waited;
    sb = new();
    n_items = 0;
    calm_in = 0;
    for (int i = 0; i < 8; i++) recent[i] = 12'hfff;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;

    // directed
    send(snea_pkg::OP_RD_GRAD, 12'd0, 12'd0, 16'd0, 16'd0, 0);
    send(snea_pkg::OP_RD_GRAD, 12'hfff, 12'hfff, 16'hffff, 16'hffff, 1);
    send(snea_pkg::OP_RD_MAT, 12'd0, 12'd0, 16'd0, 16'd0, 0);
    send(snea_pkg::OP_RD_MAT, 12'd0, 12'd1, 16'd0, 16'd0, 0);
    send(snea_pkg::OP_RD_MAT, 12'hfff, 12'hfff, 16'hffff, 16'hffff, 1);
    send(snea_pkg::OP_NONE, 12'hfff, 12'hfff, 16'hffff, 16'hffff, 1);
    send(snea_pkg::OP_ELEM, 12'hfff, 12'd0, 16'hffff, 16'hffff, 1);
    send(snea_pkg::OP_ELEM, 12'hfff, 12'd0, 16'hffff, 16'hffff, 1);
    send(snea_pkg::OP_RD_GRAD, 12'hfff, 12'd0, 16'd0, 16'd0, 0);
    send(snea_pkg::OP_ELEM, 12'd4000, 12'd0, 16'd0, 16'd5, 0);
    send(snea_pkg::OP_ELEM, 12'd4001, 12'd0, 16'd1, 16'd7, 0);
    send(snea_pkg::OP_ELEM, 12'd4002, 12'd0, 16'hffff, 16'd0, 1);
    send(snea_pkg::OP_RD_MAT, 12'd4000, 12'd4002, 16'd0, 16'd0, 0);
    send(snea_pkg::OP_RD_MAT, 12'd4002, 12'd4001, 16'd0, 16'd0, 0);
    send(snea_pkg::OP_ELEM, 12'd0, 12'd0, 16'd300, 16'd9, 0);
    send(snea_pkg::OP_ELEM, 12'd1, 12'd0, 16'd400, 16'd9, 1);
    send(snea_pkg::OP_RD_MAT, 12'd0, 12'd1, 16'd0, 16'd0, 0);
    // row too long: one cell so no insertions
    for (int i = 0; i < MaxRow + 1; i++)
      send(snea_pkg::OP_ELEM, 12'd4090, 12'd0, 16'($urandom), 16'($urandom), 0);
    send(snea_pkg::OP_ELEM, 12'd4090, 12'd0, 16'd3, 16'd11, 1);
    send(snea_pkg::OP_RD_MAT, 12'd4090, 12'd4090, 16'd0, 16'd0, 0);

    // random
    while (n_items < 290) begin
      calm_in = (n_items >= 120 && n_items < 180);
      r = $urandom_range(0, 99);
      if (r < 15) send_row(1, 0);
      else if (r < 45) send_row($urandom_range(1, 3), 1);
      else if (r < 65)
        send(snea_pkg::OP_RD_GRAD,
             ($urandom_range(0, 1) ? recent[$urandom_range(0, 7)] : 12'($urandom)),
             12'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 92)
        send(snea_pkg::OP_RD_MAT, recent[$urandom_range(0, 7)],
             ($urandom_range(0, 2) ? recent[$urandom_range(0, 7)] : 12'($urandom)),
             16'($urandom), 16'($urandom), 1'($urandom));
      else
        send(snea_pkg::OP_NONE, 12'($urandom), 12'($urandom), 16'($urandom),
             16'($urandom), 1'($urandom));
    end
    s_tvalid_i = 0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 2000000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sparse_normal_equation_accumulator verification clean");
    end else begin
      $display("sparse_normal_equation_accumulator verification failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/snea_pkg.sv
rtl/snea_ctrl.sv
rtl/snea_dp.sv
rtl/sparse_normal_equation_accumulator.sv
bench/tb.sv
